// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== hw/rtl/fspa_pkg.sv =====
// ----------------------------------------------------------------------------
// fspa_pkg
// Shared codes and widths of the fixed slot pool allocator.
// ----------------------------------------------------------------------------
package fspa_pkg;

   localparam int STRIDE_W   = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BASE_ADDRESS = 2'd0,
      REG_POOL_BYTES   = 2'd1,
      REG_ITEM_SIZE    = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      MODE_INIT  = 2'd0,
      MODE_ALLOC = 2'd1,
      MODE_FREE  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_POOL    = 3'd1,
      ST_FULL       = 3'd2,
      ST_BELOW_BASE = 3'd3,
      ST_BEYOND     = 3'd4,
      ST_MISALIGNED = 3'd5,
      ST_NOT_IN_USE = 3'd6
   } status_type;

endpackage

// ===== hw/rtl/fspa_ram.sv =====
// ----------------------------------------------------------------------------
// fspa_ram
// Single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module fspa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/fixed_slot_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator
// Free-list pool allocator over equal slots, links kept in two RAMs.
// ----------------------------------------------------------------------------
// Requests enter on the req_ stream: req_tuser carries the mode (init, alloc,
// free) and req_tdata the address to free. Each init, alloc or free request
// yields exactly one response on the rsp_ stream with status, slot address,
// slot index and the allocated count; an unused mode code is dropped silently.
// The pool is described by three registers written through the csr_ port; the
// user must write them only while the block is idle, which it does not enforce.
// One request is in flight at a time. An alloc reads the free head and links
// the slot in two write steps. A free and an init both run a 32-step restoring
// divider by the slot stride, and init then sweeps every entry of the link
// RAMs, one per cycle, to rebuild the free chain. A request rejected at
// acceptance goes straight to the response; a free fails the range or alignment
// check after the divider, and the in-use check after reading the slot's links.
// The response sits in an output register; a stalled receiver holds it there,
// and the next request is accepted once the engine is idle, while that
// response may still be waiting.
// Synchronous reset empties the pool bookkeeping: no slots, no chains, count
// zero. The link RAMs are not cleared; init writes every entry before use.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_slot_pool_allocator
   import fspa_pkg::*;
#(
   parameter int MAX_SLOTS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] address
   input  logic [REQ_USER_W-1:0] req_tuser,   // [1:0] mode
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [2:0] status, [34:3] slot_address,
                                              // [42:35] slot_index,
                                              // [51:43] item_count, [55:52] zero
);

   localparam int IW = $clog2(MAX_SLOTS);      // slot index
   localparam int LW = IW + 1;                 // link, all ones means none
   localparam int CW = $clog2(MAX_SLOTS + 1);  // counts up to MAX_SLOTS
   localparam int PW = IW + STRIDE_W;          // index times stride
   localparam logic [LW-1:0] NONE = {LW{1'b1}};

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_POST, S_SWEEP, S_ALLOC_W1, S_ALLOC_W2,
      S_FREE_CHK, S_FREE_W1, S_FREE_W2, S_FREE_W3, S_RESP
   } state_type;

   // Configuration registers.
   logic [31:0] base_ff, pool_ff;
   logic [15:0] isize_ff;

   // Sequencer and bookkeeping.
   state_type       state_ff, state_in;
   mode_type        mode_ff, mode_in;
   logic [16:0]     rem_ff, rem_in;
   logic [31:0]     quo_ff, quo_in;
   logic [4:0]      dcnt_ff, dcnt_in;
   logic [IW-1:0]   sweep_ff, sweep_in;
   logic [CW-1:0]   slot_total_ff, slot_total_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [LW-1:0]   used_head_ff, used_head_in;
   logic [LW-1:0]   used_tail_ff, used_tail_in;
   logic [LW-1:0]   free_head_ff, free_head_in;
   logic [IW-1:0]   pos_ff, pos_in;
   logic [LW-1:0]   nx_ff, nx_in;
   logic [LW-1:0]   pv_ff, pv_in;
   logic [PW-1:0]   prod_ff, prod_in;
   status_type      res_status_ff, res_status_in;
   logic [IW-1:0]   res_idx_ff, res_idx_in;
   logic            res_ok_ff, res_ok_in;
   logic            rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // RAM ports: A holds {in_use, next}, B holds prev.
   logic          a_we, b_we;
   logic [IW-1:0] a_waddr, b_waddr, rd_addr;
   logic [LW:0]   a_wdata, a_rdata;
   logic [LW-1:0] b_wdata, b_rdata;

   fspa_ram #(.WIDTH(LW + 1), .DEPTH(MAX_SLOTS)) u_next_ram (
      .clock (clock), .we (a_we), .waddr (a_waddr), .wdata (a_wdata),
      .raddr (rd_addr), .rdata (a_rdata)
   );

   fspa_ram #(.WIDTH(LW), .DEPTH(MAX_SLOTS)) u_prev_ram (
      .clock (clock), .we (b_we), .waddr (b_waddr), .wdata (b_wdata),
      .raddr (rd_addr), .rdata (b_rdata)
   );

   logic [STRIDE_W-1:0] stride;
   logic [17:0]         dshift;
   logic [17:0]         ddiff;
   logic                is_head;
   logic                in_sweep;
   logic [CW-1:0]       count_dec;
   logic [31:0]         idx_wide, cnt_wide;

   assign stride  = {1'b0, isize_ff} + STRIDE_W'(8);
   assign dshift  = {rem_ff, quo_ff[31]};
   assign ddiff   = dshift - {1'b0, stride};
   assign is_head = (LW'(pos_ff) == used_head_ff);
   assign count_dec = (count_ff != '0) ? count_ff - CW'(1) : count_ff;
   // While init sweeps, the new slot total is set but count and free head are old.
   assign in_sweep = (state_ff == S_SWEEP);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // The only reads: the free head at acceptance of an alloc, and the
   // freed slot once the divider has produced its index.
   assign rd_addr = (state_ff == S_POST) ? quo_ff[IW-1:0] : free_head_ff[IW-1:0];

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dcnt_in       = dcnt_ff;
      sweep_in      = sweep_ff;
      slot_total_in = slot_total_ff;
      count_in      = count_ff;
      used_head_in  = used_head_ff;
      used_tail_in  = used_tail_ff;
      free_head_in  = free_head_ff;
      pos_in        = pos_ff;
      nx_in         = nx_ff;
      pv_in         = pv_ff;
      prod_in       = prod_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_ok_in     = res_ok_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      a_we          = 1'b0;
      a_waddr       = pos_ff;
      a_wdata       = '0;
      b_we          = 1'b0;
      b_waddr       = pos_ff;
      b_wdata       = NONE;
      idx_wide      = 32'(res_idx_ff);
      cnt_wide      = 32'(count_ff);

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in    = mode_type'(req_tuser);
               res_ok_in  = 1'b0;
               res_idx_in = '0;
               rem_in     = '0;
               dcnt_in    = '0;
               unique case (req_tuser)
                  MODE_INIT: begin
                     quo_in   = pool_ff;
                     state_in = S_DIV;
                  end
                  MODE_ALLOC: begin
                     pos_in = free_head_ff[IW-1:0];
                     if (base_ff == '0) begin
                        res_status_in = ST_NO_POOL;
                        state_in      = S_RESP;
                     end else if (free_head_ff == NONE) begin
                        res_status_in = ST_FULL;
                        state_in      = S_RESP;
                     end else begin
                        state_in = S_ALLOC_W1;
                     end
                  end
                  MODE_FREE: begin
                     quo_in = req_tdata - base_ff;
                     if (base_ff == '0) begin
                        res_status_in = ST_NO_POOL;
                        state_in      = S_RESP;
                     end else if (req_tdata < base_ff) begin
                        res_status_in = ST_BELOW_BASE;
                        state_in      = S_RESP;
                     end else begin
                        state_in = S_DIV;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // One restoring step per cycle: quotient bits shift in from the right.
         S_DIV: begin
            if (!ddiff[17]) begin
               rem_in = ddiff[16:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = dshift[16:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd31) begin
               state_in = S_POST;
            end
         end

         S_POST: begin
            pos_in = quo_ff[IW-1:0];
            if (mode_ff == MODE_INIT) begin
               slot_total_in = (quo_ff >= 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(quo_ff);
               sweep_in      = '0;
               state_in      = S_SWEEP;
            end else if (quo_ff >= 32'(slot_total_ff)) begin
               res_status_in = ST_BEYOND;
               state_in      = S_RESP;
            end else if (rem_ff != '0) begin
               res_status_in = ST_MISALIGNED;
               state_in      = S_RESP;
            end else begin
               state_in = S_FREE_CHK;
            end
         end

         // Rebuild the free chain in index order and clear every in-use bit.
         S_SWEEP: begin
            a_we    = 1'b1;
            a_waddr = sweep_ff;
            b_we    = 1'b1;
            b_waddr = sweep_ff;
            a_wdata = {1'b0, NONE};
            if ((CW + 1)'(sweep_ff) + (CW + 1)'(1) < (CW + 1)'(slot_total_ff)) begin
               a_wdata = {1'b0, LW'(sweep_ff) + LW'(1)};
            end
            b_wdata = (sweep_ff == '0) ? NONE : LW'(sweep_ff) - LW'(1);
            sweep_in = sweep_ff + IW'(1);
            if (sweep_ff == IW'(MAX_SLOTS - 1)) begin
               used_head_in  = NONE;
               used_tail_in  = NONE;
               free_head_in  = (slot_total_ff != '0) ? '0 : NONE;
               count_in      = '0;
               res_status_in = (base_ff == '0) ? ST_NO_POOL : ST_OK;
               state_in      = S_RESP;
            end
         end

         // Link the old tail to the new slot and point the slot back at it.
         S_ALLOC_W1: begin
            nx_in   = a_rdata[LW-1:0];
            prod_in = PW'(pos_ff) * PW'(stride);
            a_we    = (used_head_ff != NONE);
            a_waddr = used_tail_ff[IW-1:0];
            a_wdata = {1'b1, LW'(pos_ff)};
            b_we    = 1'b1;
            b_waddr = pos_ff;
            b_wdata = used_tail_ff;
            state_in = S_ALLOC_W2;
         end

         S_ALLOC_W2: begin
            a_we    = 1'b1;
            a_waddr = pos_ff;
            a_wdata = {1'b1, NONE};
            b_we    = (nx_ff != NONE);
            b_waddr = nx_ff[IW-1:0];
            b_wdata = NONE;
            free_head_in = nx_ff;
            if (used_head_ff == NONE) begin
               used_head_in = LW'(pos_ff);
            end
            used_tail_in  = LW'(pos_ff);
            count_in      = count_ff + CW'(1);
            res_status_in = ST_OK;
            res_idx_in    = pos_ff;
            res_ok_in     = 1'b1;
            state_in      = S_RESP;
         end

         S_FREE_CHK: begin
            nx_in      = a_rdata[LW-1:0];
            pv_in      = b_rdata;
            res_idx_in = pos_ff;
            if (!a_rdata[LW]) begin
               res_status_in = ST_NOT_IN_USE;
               state_in      = S_RESP;
            end else begin
               state_in = S_FREE_W1;
            end
         end

         // The freed slot becomes the new free head.
         S_FREE_W1: begin
            a_we    = 1'b1;
            a_waddr = pos_ff;
            a_wdata = {1'b0, free_head_ff};
            b_we    = 1'b1;
            b_waddr = pos_ff;
            b_wdata = NONE;
            state_in = S_FREE_W2;
         end

         // Unlink from the used chain.
         S_FREE_W2: begin
            a_we    = !is_head;
            a_waddr = pv_ff[IW-1:0];
            a_wdata = {1'b1, nx_ff};
            b_we    = (nx_ff != NONE);
            b_waddr = nx_ff[IW-1:0];
            b_wdata = is_head ? NONE : pv_ff;
            state_in = S_FREE_W3;
         end

         S_FREE_W3: begin
            b_we    = (free_head_ff != NONE);
            b_waddr = free_head_ff[IW-1:0];
            b_wdata = LW'(pos_ff);
            if (is_head) begin
               used_head_in = nx_ff;
               if (nx_ff == NONE) begin
                  used_tail_in = NONE;
               end
            end else if (nx_ff == NONE) begin
               used_tail_in = pv_ff;
            end
            free_head_in = LW'(pos_ff);
            count_in     = count_dec;
            if (count_dec == '0) begin
               used_head_in = NONE;
               used_tail_in = NONE;
            end
            res_status_in = ST_OK;
            state_in      = S_RESP;
         end

         S_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {4'b0, cnt_wide[8:0], idx_wide[7:0],
                                res_ok_ff ? base_ff + 32'(prod_ff) : 32'd0,
                                res_status_ff};
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         pool_ff       <= '0;
         isize_ff      <= 16'd1;
         state_ff      <= S_IDLE;
         slot_total_ff <= '0;
         count_ff      <= '0;
         used_head_ff  <= NONE;
         used_tail_ff  <= NONE;
         free_head_ff  <= NONE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_BASE_ADDRESS: base_ff  <= csr_wdata;
               REG_POOL_BYTES:   pool_ff  <= csr_wdata;
               REG_ITEM_SIZE:    isize_ff <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
         state_ff      <= state_in;
         slot_total_ff <= slot_total_in;
         count_ff      <= count_in;
         used_head_ff  <= used_head_in;
         used_tail_ff  <= used_tail_in;
         free_head_ff  <= free_head_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      mode_ff       <= mode_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dcnt_ff       <= dcnt_in;
      sweep_ff      <= sweep_in;
      pos_ff        <= pos_in;
      nx_ff         <= nx_in;
      pv_ff         <= pv_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_ok_ff     <= res_ok_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   // Bookkeeping invariants of the chains.
   `ASSERT_ALWAYS(a_count_bound, clock, reset, !in_sweep |-> count_ff <= slot_total_ff, "count high")
   `ASSERT_ALWAYS(a_empty_used, clock, reset, (count_ff == '0) |-> (used_head_ff == NONE && used_tail_ff == NONE), "used chain not empty at zero count")
   `ASSERT_NEVER(a_free_head_range, clock, reset, !in_sweep && free_head_ff != NONE && (CW + 1)'(free_head_ff) >= (CW + 1)'(slot_total_ff), "free head outside the pool")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Random and directed check of the fixed slot pool allocator's responses.
// ----------------------------------------------------------------------------
// Requests (init, alloc, free and the unused mode) are queued by an initial
// block in phases. Between phases the pool registers are rewritten while the
// block is idle. A clocked driver offers each queued request after a random
// gap, and a clocked monitor takes responses after a random stall. Each
// accepted request runs through a behavioral copy of the allocator, and its
// response is queued and later compared field by field with what the block
// returns.
// ----------------------------------------------------------------------------
module testbench;
   import fspa_pkg::*;

   localparam int  SLOTS     = 256;
   localparam int  NO_LINK   = 32'hFFFF;
   localparam int  WDOG_MAX  = 20000;
   // The slowest request is an init, which divides and then sweeps all SLOTS entries; SETTLE waits longer than that.
   localparam int  SETTLE    = 400;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] address;
   } pool_request_t;

   // Declared from the highest bits down, so status lands in the lowest bits.
   typedef struct packed {
      logic [8:0]  item_count;
      logic [7:0]  slot_index;
      logic [31:0] slot_address;
      logic [2:0]  status;
   } pool_response_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   fixed_slot_pool_allocator dut (.*);

   always #5 clock = ~clock;

   // Pool model: registers, link arrays and the chain heads.
   logic [31:0] pool_base;
   logic [31:0] pool_len;
   logic [15:0] payload_size;
   int          next_slot[SLOTS];
   int          prev_slot[SLOTS];
   bit          slot_busy[SLOTS];
   int          used_first, used_last, free_first, busy_count, slot_count;

   pool_request_t  pending_requests[$];
   pool_response_t expected_responses[$];
   int  error_count = 0;
   int  wdog = 0;
   bit  sender_hold = 1'b0;      // sender waits for the pool to drain
   int  long_stall = 0;          // cycles the receiver still holds off
   int  send_gap = 0, take_gap = 0;
   int  live[$];                 // candidate slot addresses queued with allocs, to free later
   bit  req_taken = 1'b0;        // a request was accepted at the last rising edge
   bit  rsp_taken = 1'b0;        // a response was taken at the last rising edge

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void link_next(int i, int v);
      if (i >= 0 && i < SLOTS) next_slot[i] = v;
   endfunction

   function automatic void link_prev(int i, int v);
      if (i >= 0 && i < SLOTS) prev_slot[i] = v;
   endfunction

   function automatic int follow_next(int i);
      return (i >= 0 && i < SLOTS) ? next_slot[i] : NO_LINK;
   endfunction

   function automatic int follow_prev(int i);
      return (i >= 0 && i < SLOTS) ? prev_slot[i] : NO_LINK;
   endfunction

   function automatic void reset_pool();
      pool_base = 0; pool_len = 0; payload_size = 1;
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      used_first = NO_LINK; used_last = NO_LINK; free_first = NO_LINK;
      busy_count = 0; slot_count = 0;
   endfunction

   // Returns 0 for the unused mode, which produces no response.
   function automatic bit pool_outcome(input pool_request_t rq, output pool_response_t rs);
      logic [16:0] stride;
      logic [31:0] offset, quotient;
      int          n, pos, nf, nx, pv, idx;
      stride = {1'b0, payload_size} + 17'd8;
      rs = '0;
      case (rq.mode)
         MODE_INIT: begin
            n = pool_len / stride;
            if (n > SLOTS) n = SLOTS;
            slot_count = n;
            for (int i = 0; i < SLOTS; i++) begin
               next_slot[i] = (i + 1 < n) ? i + 1 : NO_LINK;
               prev_slot[i] = (i == 0) ? NO_LINK : i - 1;
               slot_busy[i] = 1'b0;
            end
            used_first = NO_LINK; used_last = NO_LINK;
            free_first = (n > 0) ? 0 : NO_LINK;
            busy_count = 0;
            rs.status = (pool_base == 0) ? ST_NO_POOL : ST_OK;
         end
         MODE_ALLOC: begin
            if (pool_base == 0) rs.status = ST_NO_POOL;
            else if (free_first == NO_LINK || free_first >= SLOTS) rs.status = ST_FULL;
            else begin
               pos = free_first;
               if (used_first == NO_LINK) used_first = pos;
               else link_next(used_last, pos);
               nf = follow_next(pos);
               free_first = nf;
               if (nf != NO_LINK) link_prev(nf, NO_LINK);
               link_next(pos, NO_LINK);
               link_prev(pos, used_last);
               used_last = pos;
               slot_busy[pos] = 1'b1;
               busy_count++;
               rs.status = ST_OK;
               rs.slot_address = pool_base + pos * stride;
               rs.slot_index = pos[7:0];
            end
         end
         MODE_FREE: begin
            offset = rq.address - pool_base;
            quotient = offset / stride;
            idx = quotient;
            if (pool_base == 0) rs.status = ST_NO_POOL;
            else if (rq.address < pool_base) rs.status = ST_BELOW_BASE;
            else if (quotient >= slot_count || quotient >= SLOTS) rs.status = ST_BEYOND;
            else if (offset % stride != 0) rs.status = ST_MISALIGNED;
            else if (!slot_busy[idx]) begin
               rs.status = ST_NOT_IN_USE;
               rs.slot_index = idx[7:0];
            end else begin
               nx = follow_next(idx);
               pv = follow_prev(idx);
               if (idx == used_first) begin
                  used_first = nx;
                  if (nx != NO_LINK) link_prev(nx, NO_LINK);
                  else used_last = NO_LINK;
               end else begin
                  link_next(pv, nx);
                  if (nx != NO_LINK) link_prev(nx, pv);
                  else used_last = pv;
               end
               link_next(idx, free_first);
               link_prev(idx, NO_LINK);
               if (free_first != NO_LINK) link_prev(free_first, idx);
               free_first = idx;
               slot_busy[idx] = 1'b0;
               if (busy_count > 0) busy_count--;
               if (busy_count == 0) begin
                  used_first = NO_LINK; used_last = NO_LINK;
               end
               rs.status = ST_OK;
               rs.slot_index = idx[7:0];
            end
         end
         default: return 1'b0;
      endcase
      rs.item_count = busy_count[8:0];
      return 1'b1;
   endfunction

   // Handshakes seen at the rising edge, used by the falling-edge processes.
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
   end

   // Driver: one request at a time from the pending queue, after a random gap.
   always @(negedge clock) begin
      pool_request_t  rq;
      pool_response_t rs;
      if (!reset) begin
         if (req_taken) begin
            rq = {req_tuser, req_tdata};
            if (pool_outcome(rq, rs)) expected_responses.push_back(rs);
            void'(pending_requests.pop_front());
            send_gap = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
         end
         if (sender_hold || pending_requests.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_requests[0].address;
            req_tuser  <= pending_requests[0].mode;
         end
      end
   end

   // Monitor: compare at the rising edge; the next stall is drawn at the falling edge below.
   always @(posedge clock) begin
      pool_response_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[51:0];
         if (expected_responses.size() == 0) begin
            $display("unexpected response %0h at %0t", rsp_tdata, $realtime);
            error_count++;
         end else begin
            want = expected_responses.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
            if (got.slot_address !== want.slot_address)
               report_mismatch("slot_address", got.slot_address, want.slot_address);
            if (got.slot_index !== want.slot_index)
               report_mismatch("slot_index", got.slot_index, want.slot_index);
            if (got.item_count !== want.item_count)
               report_mismatch("item_count", got.item_count, want.item_count);
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            take_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         end
         if (long_stall > 0) begin
            long_stall--;
            rsp_tready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         wdog <= 0;
      else if (wdog >= WDOG_MAX) begin
         $display("testbench failed");
         $finish;
      end else
         wdog <= wdog + 1;
   end

   task automatic queue_request(input mode_type m, input logic [31:0] a);
      pending_requests.push_back('{mode: m, address: a});
   endtask

   // Wait until the block has drained, then let a slow request finish.
   task automatic wait_idle();
      while (pending_requests.size() != 0 || expected_responses.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input csr_reg_type r, input logic [31:0] v);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= r; csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      case (r)
         REG_BASE_ADDRESS: pool_base = v;
         REG_POOL_BYTES:   pool_len = v;
         default:          payload_size = v[15:0];
      endcase
   endtask

   task automatic set_pool(input logic [31:0] b, input logic [31:0] len,
                           input logic [15:0] sz);
      write_register(REG_BASE_ADDRESS, b);
      write_register(REG_POOL_BYTES, len);
      write_register(REG_ITEM_SIZE, {16'd0, sz});
   endtask

   // A random mix leaning toward well-formed alloc and free of live slots.
   task automatic random_phase(input int count);
      int kind;
      logic [31:0] stride, a;
      stride = payload_size + 8;
      for (int k = 0; k < count; k++) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            queue_request(MODE_ALLOC, $urandom);
            live.push_back(pool_base + $urandom_range(0, 40) * stride);
         end else if (kind < 85 && live.size() > 0) begin
            a = live[$urandom_range(0, live.size() - 1)];
            queue_request(MODE_FREE, a);
         end else if (kind < 92) begin
            a = $urandom;
            if ($urandom_range(0, 1)) a = pool_base + $urandom_range(0, 300) * stride
                                            + $urandom_range(0, 2);
            queue_request(MODE_FREE, a);
         end else if (kind < 95) begin
            queue_request(MODE_INIT, $urandom);
         end else begin
            pending_requests.push_back('{mode: 2'd3, address: $urandom});
         end
      end
   endtask

   initial begin
      reset_pool();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Before any init: no pool, then alloc full and free beyond.
      queue_request(MODE_ALLOC, 32'h0);
      queue_request(MODE_FREE, 32'h0);
      queue_request(MODE_INIT, 32'hFFFF_FFFF);
      wait_idle();
      set_pool(32'h0000_1000, 32'h0, 16'd1);
      queue_request(MODE_ALLOC, 32'h0);
      queue_request(MODE_FREE, 32'h0000_1000);
      queue_request(MODE_INIT, 32'h0);   // empty pool
      queue_request(MODE_ALLOC, 32'h0);
      wait_idle();

      // Small pool of four slots, stride 12: every status but no pool, and the tail case.
      set_pool(32'h0000_1000, 32'd48, 16'd4);
      queue_request(MODE_INIT, 32'h0);
      repeat (5) queue_request(MODE_ALLOC, 32'h0);
      queue_request(MODE_FREE, 32'h0000_0FFF);          // below base
      queue_request(MODE_FREE, 32'h0000_1030);          // beyond
      queue_request(MODE_FREE, 32'h0000_1005);          // misaligned
      queue_request(MODE_FREE, 32'h0000_1024);          // tail slot
      queue_request(MODE_FREE, 32'h0000_1024);          // not in use
      queue_request(MODE_FREE, 32'h0000_100C);          // middle
      queue_request(MODE_FREE, 32'h0000_1000);          // head
      queue_request(MODE_ALLOC, 32'h0);
      pending_requests.push_back('{mode: 2'd3, address: 32'hFFFF_FFFF});
      queue_request(MODE_FREE, 32'hFFFF_FFFF);
      wait_idle();

      // Largest stride and largest addresses, wrapping slot addresses.
      set_pool(32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'hFFFF);
      queue_request(MODE_INIT, 32'h0);
      repeat (3) queue_request(MODE_ALLOC, 32'h0);
      queue_request(MODE_FREE, 32'hFFFF_FFF0);
      wait_idle();

      // Full pool of 256 slots, stride 9, with the receiver held off long.
      set_pool(32'h8000_0000, 32'hFFFF_FFFF, 16'd1);
      queue_request(MODE_INIT, 32'h0);
      wait_idle();
      live.delete();
      long_stall = 300;
      random_phase(150);
      wait_idle();

      // Sender pauses part way until everything has come back, then resumes.
      random_phase(20);
      repeat (60) @(posedge clock);
      sender_hold = 1'b1;
      wait (expected_responses.size() == 0);
      repeat (20) @(posedge clock);
      sender_hold = 1'b0;
      wait_idle();

      // Medium pools with random shape.
      for (int p = 0; p < 3; p++) begin
         set_pool($urandom | 32'h1, $urandom_range(0, 2000), $urandom_range(1, 64));
         queue_request(MODE_INIT, $urandom);
         live.delete();
         random_phase(70);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ===== fixed_slot_pool_allocator.f =====
+incdir+hw/rtl
hw/rtl/fspa_pkg.sv
hw/rtl/fspa_ram.sv
hw/rtl/fixed_slot_pool_allocator.sv
test/testbench.sv
